// ===== hdl/rita_pkg.sv =====
// shared types and constants for the radix integer to ascii unit
// depends on nothing; imported by rita_ctrl, rita_dp, the top level and the testbench
package rita_pkg;

	localparam int unsigned MAX_RESULTS = 22;
	localparam logic [6:0]  MINUS_CODE  = 7'h2D;
	localparam logic [4:0]  RADIX_MIN   = 5'd8;
	localparam logic [4:0]  RADIX_MAX   = 5'd16;

	typedef struct packed {
		logic [63:0] number_bits;
		logic        signed_mode;
		logic [4:0]  radix;
	} number_beat_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last_char;
	} char_beat_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic store_digit;
		logic rd_issue;
		logic out_sign;
		logic out_digit;
	} rita_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic step_last;
		logic div_end;
		logic sign_needed;
		logic out_free;
		logic last_digit;
	} rita_stat_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = 7'h30 + {3'd0, d};
		end else begin
			c = 7'h41 + {3'd0, d} - 7'd10;
		end
		return c;
	endfunction

endpackage

// ===== hdl/radix_integer_to_ascii_unit.sv =====
// top level of the radix integer to ascii unit
// depends on rita_pkg, rita_ctrl and rita_dp
//
// usage
// - number channel: number_valid / number_stall / number_beat carry one value,
//   a signed flag and a base; bases below 8 act as 8, above 16 as 16
// - char channel: char_valid / char_stall / char_beat carry one ascii
//   character per beat, most significant digit first, an optional leading
//   minus sign, upper-case letters, last_char set on the final beat
// - one number at a time: number_stall is high from the accepted beat until
//   the last character has been loaded into the output register
// - each digit takes byte-serial long division (eight restoring steps per
//   cycle on the 64-bit quotient register), then a write to the digit store
// - characters then leave through a store read, then an output load each;
//   the sign beat needs only an output load when present
// - a number yields at most 22 digits
// - the next number is taken while the final character still waits in the
//   output register
// - a stalled receiver holds the output register; the sequencer waits only
//   when it has a sign or a digit to load, the division runs on regardless
// - reset clears the sequencer, counters and output valid; the digit store
//   needs no clearing since every entry is written before it is read
module radix_integer_to_ascii_unit
	import rita_pkg::*;
#(
	parameter int unsigned DIGIT_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         number_valid,
	output logic         number_stall,
	input  number_beat_t number_beat,
	output logic         char_valid,
	input  logic         char_stall,
	output char_beat_t   char_beat
);

	// command and status between sequencer and datapath
	rita_cmd_t  cmd;
	rita_stat_t stat;

	rita_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.number_valid (number_valid),
		.number_stall (number_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	rita_dp #(
		.DIGIT_DEPTH (DIGIT_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_beat (number_beat),
		.cmd         (cmd),
		.stat        (stat),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_beat   (char_beat)
	);

endmodule

// ===== hdl/rita_ctrl.sv =====
// sequencer for the radix integer to ascii unit
// depends on rita_pkg; drives command beats into rita_dp
module rita_ctrl
	import rita_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       number_valid,
	output logic       number_stall,
	input  rita_stat_t stat,
	output rita_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIV   = 6'b000010,
		S_STORE = 6'b000100,
		S_SIGN  = 6'b001000,
		S_READ  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		number_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				number_stall = 1'b0;
				if (number_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.step_last) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store_digit = 1'b1;
				state_d = stat.div_end ? S_SIGN : S_DIV;
			end
			S_SIGN: begin
				if (!stat.sign_needed) begin
					state_d = S_READ;
				end else if (stat.out_free) begin
					cmd.out_sign = 1'b1;
					state_d      = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.out_digit = 1'b1;
					state_d = stat.last_digit ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/rita_dp.sv =====
// datapath: byte-serial division by the radix, digit store, output register
// depends on rita_pkg; controlled by rita_ctrl
module rita_dp
	import rita_pkg::*;
#(
	parameter int unsigned DIGIT_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  number_beat_t number_beat,
	input  rita_cmd_t    cmd,
	output rita_stat_t   stat,
	output logic         char_valid,
	input  logic         char_stall,
	output char_beat_t   char_beat
);

	localparam int unsigned CNT_W = $clog2(DIGIT_DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(DIGIT_DEPTH);

	logic [63:0]      quot_q;
	logic [3:0]       rem_q;
	logic [4:0]       base_q;
	logic             minus_q;
	logic [2:0]       step_q;
	logic [CNT_W-1:0] count_q;
	logic [3:0]       rd_data_q;
	logic             char_valid_q;
	char_beat_t       char_beat_q;

	logic [3:0]       mem [DIGIT_DEPTH];

	logic [4:0]       base_in;
	logic             minus_in;
	logic [63:0]      mag_in;
	logic [3:0]       rem_d;
	logic [7:0]       qbits_d;
	logic [CNT_W-1:0] rd_cnt;

	// clamp the base and take the magnitude
	always_comb begin
		base_in = number_beat.radix;
		if (base_in < RADIX_MIN) begin
			base_in = RADIX_MIN;
		end
		if (base_in > RADIX_MAX) begin
			base_in = RADIX_MAX;
		end
		minus_in = number_beat.signed_mode & number_beat.number_bits[63];
		mag_in   = minus_in ? (~number_beat.number_bits + 64'd1) : number_beat.number_bits;
	end

	// eight restoring steps on the top byte of the quotient register
	always_comb begin
		logic [4:0] r;
		logic [4:0] t;
		r       = {1'b0, rem_q};
		qbits_d = '0;
		for (int i = 0; i < 8; i++) begin
			t = {r[3:0], quot_q[63-i]};
			if (t >= base_q) begin
				r           = t - base_q;
				qbits_d[7-i] = 1'b1;
			end else begin
				r = t;
			end
		end
		rem_d = r[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q  <= '0;
			rem_q   <= '0;
			step_q  <= '0;
			count_q <= '0;
			minus_q <= 1'b0;
			base_q  <= RADIX_MIN;
		end else begin
			if (cmd.load) begin
				quot_q  <= mag_in;
				rem_q   <= '0;
				step_q  <= '0;
				count_q <= '0;
				minus_q <= minus_in;
				base_q  <= base_in;
			end else if (cmd.div_step) begin
				quot_q <= {quot_q[55:0], qbits_d};
				rem_q  <= rem_d;
				step_q <= step_q + 3'd1;
			end else if (cmd.store_digit) begin
				rem_q   <= '0;
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.out_digit) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign rd_cnt = count_q - CNT_W'(1);

	// digit store, written least significant digit first
	always_ff @(posedge clk) begin
		if (cmd.store_digit) begin
			mem[count_q[IDX_W-1:0]] <= rem_q;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem[rd_cnt[IDX_W-1:0]];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (cmd.out_sign || cmd.out_digit) begin
			char_valid_q <= 1'b1;
		end else if (!char_stall) begin
			char_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_sign) begin
			char_beat_q.char_code <= MINUS_CODE;
			char_beat_q.last_char <= 1'b0;
		end else if (cmd.out_digit) begin
			char_beat_q.char_code <= digit_char(rd_data_q);
			char_beat_q.last_char <= (count_q == CNT_W'(1));
		end
	end

	assign char_valid = char_valid_q;
	assign char_beat  = char_beat_q;

	assign stat.step_last   = (step_q == 3'd7);
	assign stat.div_end     = (quot_q == 64'd0) || (count_q == CNT_W'(DIGIT_DEPTH - 1));
	assign stat.sign_needed = minus_q && (count_q < CNT_W'(MAX_RESULTS));
	assign stat.out_free    = !char_valid_q || !char_stall;
	assign stat.last_digit  = (count_q == CNT_W'(1));

endmodule

// ===== tb/tb.sv =====
// testbench for radix_integer_to_ascii_unit: number beats in, ascii character beats out
// depends on rita_pkg and the unit; predicts each character and checks it in order
// random valid gaps on the number side, random stall on the character side

module tb;
	import rita_pkg::*;

	localparam int unsigned DIGIT_DEPTH = 32;
	localparam int unsigned RANDOM_NUMBERS = 205;

	// clock, reset and the two channels
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         number_valid = 1'b0;
	logic         number_stall;
	number_beat_t number_beat = '0;
	logic         char_valid;
	logic         char_stall = 1'b0;
	char_beat_t   char_beat;

	// characters still owed by the unit, oldest first
	char_beat_t chars_due[$];
	char_beat_t want;

	// digit glyphs, indexed by digit value
	string glyphs = "0123456789ABCDEF";

	// when set, neither side idles
	logic calm = 1'b0;

	int numbers_sent = 0;
	int chars_checked = 0;
	int bad_beats = 0;

	radix_integer_to_ascii_unit #(
		.DIGIT_DEPTH(DIGIT_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.number_valid(number_valid),
		.number_stall(number_stall),
		.number_beat(number_beat),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_beat(char_beat)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// receiver stalls at random about 8 percent of the time, never while calm
	always @(posedge clk) begin
		char_stall <= !calm && ($urandom_range(99) < 8);
	end

	// expected characters of one accepted number, appended to chars_due
	function automatic void render_number(input number_beat_t nb);
		logic [63:0] quot;
		logic [4:0]  base;
		logic        neg;
		logic [3:0]  digs [0:DIGIT_DEPTH-1];
		int          n;
		int          k;
		char_beat_t  c;
		base = nb.radix;
		// out-of-range bases snap to the nearest legal one
		if (base < RADIX_MIN) begin
			base = RADIX_MIN;
		end
		if (base > RADIX_MAX) begin
			base = RADIX_MAX;
		end
		neg = nb.signed_mode && nb.number_bits[63];
		// magnitude taken unsigned, so the most negative value becomes 2^63
		quot = neg ? (~nb.number_bits + 64'd1) : nb.number_bits;
		n = 0;
		// digits least significant first; zero still yields one digit
		do begin
			digs[n] = 4'(quot % {59'd0, base});
			quot = quot / {59'd0, base};
			n++;
		end while (quot != 64'd0 && n < DIGIT_DEPTH);
		// sign would overflow the character budget (most negative in octal): drop it
		if (neg && n + 1 > MAX_RESULTS) begin
			neg = 1'b0;
		end
		if (neg) begin
			c.char_code = MINUS_CODE;
			c.last_char = 1'b0;
			chars_due.push_back(c);
		end
		for (k = n - 1; k >= 0; k--) begin
			c.char_code = 7'(glyphs[digs[k]]);
			c.last_char = (k == 0);
			chars_due.push_back(c);
		end
	endfunction

	// offer one number beat and hold it until taken; valid stays high afterward
	// so a following beat can go out back to back
	task automatic send_number(input logic [63:0] bits, input logic sgn, input logic [4:0] rdx);
		number_beat_t nb;
		int gap;
		nb.number_bits = bits;
		nb.signed_mode = sgn;
		nb.radix = rdx;
		// occasional sender gap of random length with valid low
		if (!calm && $urandom_range(99) < 8) begin
			gap = $urandom_range(1, 40);
			number_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_valid <= 1'b1;
		number_beat <= nb;
		do @(posedge clk); while (number_stall);
		render_number(nb);
		numbers_sent++;
	endtask

	// check every accepted character beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) begin
			if (chars_due.size() == 0) begin
				bad_beats++;
				if (bad_beats <= 10) begin
					$display("unexpected char beat: code %h last %b",
						char_beat.char_code, char_beat.last_char);
				end
			end else begin
				want = chars_due.pop_front();
				chars_checked++;
				if (char_beat.char_code !== want.char_code ||
						char_beat.last_char !== want.last_char) begin
					bad_beats++;
					if (bad_beats <= 10) begin
						$display("char mismatch: expected code %h last %b, got code %h last %b",
							want.char_code, want.last_char,
							char_beat.char_code, char_beat.last_char);
					end
				end
			end
		end
	end

	// zero, all ones and the largest positive value, in bases 8, 10 and 16
	task automatic test_extremes();
		send_number(64'd0, 1'b0, 5'd10);
		send_number(64'd0, 1'b1, 5'd16);
		send_number('1, 1'b0, 5'd8);      // longest output, 22 octal digits
		send_number('1, 1'b0, 5'd16);
		send_number('1, 1'b0, 5'd10);
		send_number('1, 1'b1, 5'd10);     // minus one
		send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 5'd10);
		send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 5'd8);
	endtask

	// each legal base once, alternating a positive and a negative value
	task automatic test_every_radix();
		int r;
		for (r = RADIX_MIN; r <= RADIX_MAX; r++) begin
			if (r % 2 == 0) begin
				send_number(64'h0123_4567_89AB_CDEF, 1'b0, 5'(r));
			end else begin
				send_number(64'hFEDC_BA98_7654_3210, 1'b1, 5'(r));
			end
		end
	endtask

	// bases below 8 act as octal, above 16 as hex
	task automatic test_radix_clamp();
		send_number(64'd12345, 1'b0, 5'd0);
		send_number(64'hFFFF_FFFF_FFFF_FF85, 1'b1, 5'd7);
		send_number(64'hDEAD_BEEF, 1'b0, 5'd17);
		send_number('1, 1'b1, 5'd31);
	endtask

	// most negative value: sign dropped in octal, kept elsewhere, plain when unsigned
	task automatic test_most_negative();
		send_number(64'h8000_0000_0000_0000, 1'b1, 5'd8);
		send_number(64'h8000_0000_0000_0000, 1'b1, 5'd10);
		send_number(64'h8000_0000_0000_0000, 1'b1, 5'd16);
		send_number(64'h8000_0000_0000_0000, 1'b0, 5'd8);
	endtask

	// random values of random length; the middle third runs with no idling
	task automatic test_random_numbers(input int count);
		int i;
		logic [63:0] bits;
		logic [4:0]  rdx;
		for (i = 0; i < count; i++) begin
			calm <= (i >= count / 3) && (i < 2 * count / 3);
			case ($urandom_range(9))
				0: begin
					// corner values near the ends of the range
					case ($urandom_range(3))
						0: bits = 64'd0;
						1: bits = '1;
						2: bits = 64'h8000_0000_0000_0000;
						default: bits = 64'h7FFF_FFFF_FFFF_FFFF;
					endcase
				end
				1, 2, 3, 4: begin
					// numbers of random length, shifted down by a random amount
					bits = {$urandom, $urandom} >> $urandom_range(63);
				end
				5, 6: begin
					// negated values of random magnitude
					bits = ~({$urandom, $urandom} >> $urandom_range(63)) + 64'd1;
				end
				default: begin
					bits = {$urandom, $urandom};
				end
			endcase
			if ($urandom_range(9) == 0) begin
				rdx = 5'($urandom_range(31));
			end else begin
				rdx = 5'($urandom_range(RADIX_MIN, RADIX_MAX));
			end
			send_number(bits, 1'($urandom_range(1)), rdx);
		end
		calm <= 1'b0;
	endtask

	initial begin
		// reset held low from the start, then released once
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_every_radix();
		test_radix_clamp();
		test_most_negative();
		test_random_numbers(RANDOM_NUMBERS);

		// stop offering, let the owed characters drain, then a short settle
		number_valid <= 1'b0;
		while (chars_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("covered %0d numbers, %0d characters checked, bases 0 to 31 incl. clamping",
			numbers_sent, chars_checked);
		$display("%0d bad character beats, %0d characters never arrived",
			bad_beats, chars_due.size());
		if (bad_beats == 0 && chars_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// hard limit, far beyond the slowest correct run
	initial begin
		#12000000;
		$display("timeout: %0d characters still owed", chars_due.size());
		$display("status: fail");
		$finish;
	end

endmodule
